>>> rtl/psp_pkg.sv
// Shared types and character codes for the selector parser.
`default_nettype none
package psp_pkg;

	localparam int CH_W  = 8;
	localparam int NUM_W = 16;
	localparam int LEN_W = 6;
	localparam int IDX_W = 5;

	localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CH_W-1:0] CH_DQUOTE  = 8'h22;
	localparam logic [CH_W-1:0] CH_HASH    = 8'h23;
	localparam logic [CH_W-1:0] CH_SQUOTE  = 8'h27;
	localparam logic [CH_W-1:0] CH_SLASH   = 8'h2F;
	localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CH_W-1:0] CH_UP_A    = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_F    = 8'h46;
	localparam logic [CH_W-1:0] CH_UP_H    = 8'h48;
	localparam logic [CH_W-1:0] CH_LO_A    = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_F    = 8'h66;

	localparam logic [LEN_W-1:0] NUMBER_LEN = 6'd2;

	typedef enum logic [2:0] {
		ST_BUSY    = 3'd0,
		ST_DONE    = 3'd1,
		ST_DONE_NC = 3'd2,
		ST_NONE    = 3'd3,
		ST_ERROR   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_EMPTY  = 2'd0,
		KIND_STRING = 2'd1,
		KIND_NUMBER = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		MODE_IDLE      = 5'b00001,
		MODE_STRING    = 5'b00010,
		MODE_HEX       = 5'b00100,
		MODE_HEX_CLOSE = 5'b01000,
		MODE_DECIMAL   = 5'b10000
	} mode_t;

	typedef struct packed {
		status_t          status;
		kind_t            kind;
		logic [NUM_W-1:0] number;
		logic [LEN_W-1:0] length;
		logic [CH_W-1:0]  lit_byte;
		logic             lit_valid;
		logic [IDX_W-1:0] lit_index;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/psp_in_if.sv
// Character input channel: valid/ready with one character per item.
`default_nettype none
interface psp_in_if import psp_pkg::*;;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface
`default_nettype wire

>>> rtl/psp_out_if.sv
// Result output channel: valid/ready with one parse result per item.
`default_nettype none
interface psp_out_if import psp_pkg::*;;
	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic [1:0]       kind;
	logic [NUM_W-1:0] number;
	logic [LEN_W-1:0] length;
	logic [CH_W-1:0]  lit_byte;
	logic             lit_valid;
	logic [IDX_W-1:0] lit_index;

	modport source (output valid, output status, output kind, output number, output length,
		output lit_byte, output lit_valid, output lit_index, input ready);
	modport sink (input valid, input status, input kind, input number, input length,
		input lit_byte, input lit_valid, input lit_index, output ready);
endinterface
`default_nettype wire

>>> rtl/psp_step.sv
// Next-state and result logic for one character of the selector parser.
`default_nettype none
module psp_step import psp_pkg::*; #(
	parameter int LITERAL_MAX = 32,
	parameter int CNT_W       = 6
) (
	input  wire mode_t            mode,
	input  wire [NUM_W-1:0]       acc,
	input  wire [CNT_W-1:0]       cnt,
	input  wire                   too_long,
	input  wire [CH_W-1:0]        ch,
	output mode_t                 mode_d,
	output logic [NUM_W-1:0]      acc_d,
	output logic [CNT_W-1:0]      cnt_d,
	output logic                  too_long_d,
	output result_t               res
);

	logic       is_dec;
	logic       is_hex;
	logic [3:0] hex_val;
	logic [NUM_W-1:0] dec_next;

	always_comb begin
		is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_hex = is_dec;
		hex_val = ch[3:0];
		if (((ch >= CH_UP_A) && (ch <= CH_UP_F)) || ((ch >= CH_LO_A) && (ch <= CH_LO_F))) begin
			is_hex = 1'b1;
			hex_val = 4'(ch[3:0] + 4'd9);
		end
		// acc * 10 + digit, wraps to 16 bits
		dec_next = NUM_W'((acc << 3) + (acc << 1) + {{(NUM_W-4){1'b0}}, ch[3:0]});
	end

	always_comb begin
		mode_d     = mode;
		acc_d      = acc;
		cnt_d      = cnt;
		too_long_d = too_long;
		res        = '0;
		res.status = ST_BUSY;
		res.kind   = KIND_EMPTY;

		unique case (mode)
			MODE_IDLE: begin
				if (ch == CH_SLASH) begin
					res.status = ST_DONE;
				end else if (ch == CH_DQUOTE) begin
					mode_d = MODE_STRING;
				end else if (ch == CH_SQUOTE) begin
					mode_d = MODE_HEX;
				end else if (ch == CH_HASH) begin
					mode_d = MODE_DECIMAL;
				end else begin
					res.status = ST_NONE;
				end
			end
			MODE_STRING: begin
				if (ch == CH_NUL) begin
					res.status = ST_ERROR;
					mode_d = MODE_IDLE;
					acc_d = '0;
					cnt_d = '0;
					too_long_d = 1'b0;
				end else if (ch == CH_DQUOTE) begin
					if (too_long) begin
						res.status = ST_ERROR;
					end else begin
						res.status = ST_DONE;
						res.kind   = KIND_STRING;
						res.length = LEN_W'(cnt);
					end
					mode_d = MODE_IDLE;
					acc_d = '0;
					cnt_d = '0;
					too_long_d = 1'b0;
				end else if (cnt < CNT_W'(LITERAL_MAX)) begin
					res.lit_byte  = ch;
					res.lit_valid = 1'b1;
					res.lit_index = IDX_W'(cnt);
					cnt_d = CNT_W'(cnt + 1'b1);
				end else begin
					too_long_d = 1'b1;
				end
			end
			MODE_HEX: begin
				if (ch == CH_SQUOTE) begin
					mode_d = MODE_HEX_CLOSE;
				end else if (!is_hex) begin
					res.status = ST_ERROR;
					mode_d = MODE_IDLE;
					acc_d = '0;
					cnt_d = '0;
					too_long_d = 1'b0;
				end else begin
					acc_d = {acc[NUM_W-5:0], hex_val};
				end
			end
			MODE_HEX_CLOSE: begin
				if (ch == CH_UP_H) begin
					res.status = ST_DONE;
					res.kind   = KIND_NUMBER;
					res.number = acc;
					res.length = NUMBER_LEN;
				end else begin
					res.status = ST_ERROR;
				end
				mode_d = MODE_IDLE;
				acc_d = '0;
				cnt_d = '0;
				too_long_d = 1'b0;
			end
			MODE_DECIMAL: begin
				if (is_dec) begin
					acc_d = dec_next;
				end else begin
					res.status = ST_DONE_NC;
					res.kind   = KIND_NUMBER;
					res.number = acc;
					res.length = NUMBER_LEN;
					mode_d = MODE_IDLE;
					acc_d = '0;
					cnt_d = '0;
					too_long_d = 1'b0;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				acc_d = '0;
				cnt_d = '0;
				too_long_d = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/presentation_selector_parser_unit.sv
// An accepted character is held in the input register, and its result is registered in the output register.
// Throughput: one character per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// The parse state updates in the same cycle as the result register, so consecutive
// characters need no bubble. Reset (arst_n low) empties both registers and
// returns the parser to idle with the accumulator, count and overflow flag cleared.
`default_nettype none
module presentation_selector_parser_unit import psp_pkg::*; #(
	parameter int LITERAL_MAX = 32
) (
	input wire         clk,
	input wire         arst_n,
	psp_in_if.sink     chr,
	psp_out_if.source  res
);

	localparam int CNT_W = $clog2(LITERAL_MAX + 1);

	logic [CH_W-1:0]  ch_s1;
	logic             vld_s1;
	mode_t            mode_q;
	logic [NUM_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             too_long_q;
	result_t          res_q;
	logic             res_vld_q;

	mode_t            mode_d;
	logic [NUM_W-1:0] acc_d;
	logic [CNT_W-1:0] cnt_d;
	logic             too_long_d;
	result_t          res_d;
	logic             advance;

	assign advance   = !res_vld_q || res.ready;
	assign chr.ready = !vld_s1 || advance;

	psp_step #(
		.LITERAL_MAX (LITERAL_MAX),
		.CNT_W       (CNT_W)
	) u_step (
		.mode       (mode_q),
		.acc        (acc_q),
		.cnt        (cnt_q),
		.too_long   (too_long_q),
		.ch         (ch_s1),
		.mode_d     (mode_d),
		.acc_d      (acc_d),
		.cnt_d      (cnt_d),
		.too_long_d (too_long_d),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chr.ready) begin
			vld_s1 <= chr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr.ready && chr.valid) begin
			ch_s1 <= chr.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			acc_q      <= '0;
			cnt_q      <= '0;
			too_long_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else if (advance) begin
			res_vld_q <= vld_s1;
			if (vld_s1) begin
				mode_q     <= mode_d;
				acc_q      <= acc_d;
				cnt_q      <= cnt_d;
				too_long_q <= too_long_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			res_q <= res_d;
		end
	end

	assign res.valid     = res_vld_q;
	assign res.status    = res_q.status;
	assign res.kind      = res_q.kind;
	assign res.number    = res_q.number;
	assign res.length    = res_q.length;
	assign res.lit_byte  = res_q.lit_byte;
	assign res.lit_valid = res_q.lit_valid;
	assign res.lit_index = res_q.lit_index;

endmodule
`default_nettype wire
